[rtl/vending_purchase_and_change_core_assert.svh]
// Assertion macros shared by the vending purchase and change core.
`ifndef VENDING_PURCHASE_AND_CHANGE_CORE_ASSERT_SVH
`define VENDING_PURCHASE_AND_CHANGE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/vpc_pkg.sv]
// Shared types, constants and tables of the vending purchase and change core.
`default_nettype none

package vpc_pkg;

   localparam int NUM_SLOTS_DEF = 3;
   localparam int NUM_DENOMS    = 6;
   localparam int CFG_SLOTS     = 3;

   localparam int STORE_W     = 16;
   localparam int ID_W        = 8;
   localparam int PRICE_W     = 16;
   localparam int QTY_W       = 16;
   localparam int PAID_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int YEN_W       = 21;
   localparam int REQ_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DENOM_IDX_W = 3;
   localparam int DENOM_W     = 13;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 24;
   localparam int MUL_A_W     = 21;
   localparam int PROD_W      = MUL_A_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [REQ_W-1:0] REQ_PURCHASE     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ADD_STOCK    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ADD_COINS    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_REDUCE_COINS = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PRODUCT = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT_FUNDS = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COIN    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FEW     = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_PRICE = 3'd3;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [ID_W-1:0]    product_id;
      logic [QTY_W-1:0]   quantity;
      logic [QTY_W-1:0]   coin_value;
      logic [PAID_W-1:0]  paid_5000;
      logic [PAID_W-1:0]  paid_1000;
      logic [PAID_W-1:0]  paid_500;
      logic [PAID_W-1:0]  paid_100;
      logic [PAID_W-1:0]  paid_50;
      logic [PAID_W-1:0]  paid_10;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [YEN_W-1:0]    total_paid;
      logic [YEN_W-1:0]    change_unpaid;
      logic [STORE_W-1:0]  give_5000;
      logic [STORE_W-1:0]  give_1000;
      logic [STORE_W-1:0]  give_500;
      logic [STORE_W-1:0]  give_100;
      logic [STORE_W-1:0]  give_50;
      logic [STORE_W-1:0]  give_10;
   } rsp_word_type;

   typedef struct packed {
      logic                   slot_hit;
      logic                   denom_hit;
      logic [DENOM_IDX_W-1:0] denom_idx;
   } lookup_type;

   typedef struct packed {
      logic                   by_recip;
      logic [DENOM_IDX_W-1:0] idx;
      logic [MUL_A_W-1:0]     operand;
   } mul_cmd_type;

   function automatic logic [DENOM_W-1:0] denom_yen(input logic [DENOM_IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 13'd5000;
         3'd1:    return 13'd1000;
         3'd2:    return 13'd500;
         3'd3:    return 13'd100;
         3'd4:    return 13'd50;
         3'd5:    return 13'd10;
         default: return '0;
      endcase
   endfunction

   // Reciprocals are floor(2**RECIP_SHIFT / yen), so the estimate is low by at most one.
   function automatic logic [RECIP_W-1:0] denom_recip(input logic [DENOM_IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 21'd3355;
         3'd1:    return 21'd16777;
         3'd2:    return 21'd33554;
         3'd3:    return 21'd167772;
         3'd4:    return 21'd335544;
         3'd5:    return 21'd1677721;
         default: return '0;
      endcase
   endfunction

   function automatic logic [STORE_W-1:0] coin_reset(input int d);
      case (d)
         0:       return 16'd10;
         1:       return 16'd20;
         2:       return 16'd30;
         3:       return 16'd50;
         4:       return 16'd100;
         5:       return 16'd200;
         default: return '0;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] slot_id_reset(input int s);
      case (s)
         0:       return 8'd1;
         1:       return 8'd2;
         2:       return 8'd3;
         default: return '0;
      endcase
   endfunction

   function automatic logic [PRICE_W-1:0] slot_price_reset(input int s);
      case (s)
         0:       return 16'd150;
         1:       return 16'd100;
         2:       return 16'd200;
         default: return '0;
      endcase
   endfunction

   function automatic logic [STORE_W-1:0] slot_stock_reset(input int s);
      case (s)
         0:       return 16'd10;
         1:       return 16'd15;
         2:       return 16'd8;
         default: return '0;
      endcase
   endfunction

   function automatic logic [PAID_W-1:0] paid_count(input req_word_type w,
                                                    input logic [DENOM_IDX_W-1:0] idx);
      case (idx)
         3'd0:    return w.paid_5000;
         3'd1:    return w.paid_1000;
         3'd2:    return w.paid_500;
         3'd3:    return w.paid_100;
         3'd4:    return w.paid_50;
         3'd5:    return w.paid_10;
         default: return '0;
      endcase
   endfunction

   function automatic logic [STORE_W-1:0] sat_add(input logic [STORE_W-1:0] a,
                                                  input logic [STORE_W-1:0] b);
      logic [STORE_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[STORE_W] ? {STORE_W{1'b1}} : sum[STORE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/vpc_lookup.sv]
// Priority search for the product slot and the denomination of a request word.
`default_nettype none

module vpc_lookup #(
   parameter int NUM_SLOTS  = vpc_pkg::NUM_SLOTS_DEF,
   parameter int SLOT_IDX_W = 2
) (
   input  logic [vpc_pkg::ID_W-1:0]    slot_id [NUM_SLOTS],
   input  logic [vpc_pkg::STORE_W-1:0] stock   [NUM_SLOTS],
   input  logic [vpc_pkg::ID_W-1:0]    product_id,
   input  logic                        need_stock,
   input  logic [vpc_pkg::QTY_W-1:0]   coin_value,
   output vpc_pkg::lookup_type         look,
   output logic [SLOT_IDX_W-1:0]       slot_idx
);

   // Scanning downwards leaves the lowest matching entry in place.
   always_comb begin
      look     = '0;
      slot_idx = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (slot_id[s] != '0 && slot_id[s] == product_id &&
             (!need_stock || stock[s] != '0)) begin
            look.slot_hit = 1'b1;
            slot_idx      = SLOT_IDX_W'(s);
         end
      end
      for (int d = vpc_pkg::NUM_DENOMS - 1; d >= 0; d--) begin
         if (vpc_pkg::QTY_W'(vpc_pkg::denom_yen(vpc_pkg::DENOM_IDX_W'(d))) == coin_value) begin
            look.denom_hit = 1'b1;
            look.denom_idx = vpc_pkg::DENOM_IDX_W'(d);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/vpc_mul_unit.sv]
// Shared multiplier with the denomination and reciprocal tables and a registered product.
`default_nettype none

module vpc_mul_unit (
   input  logic                          clock,
   input  vpc_pkg::mul_cmd_type          cmd,
   output logic [vpc_pkg::PROD_W-1:0]    prod
);

   logic [vpc_pkg::RECIP_W-1:0] factor;
   logic [vpc_pkg::PROD_W-1:0]  prod_in;
   logic [vpc_pkg::PROD_W-1:0]  prod_ff;

   assign factor  = cmd.by_recip ? vpc_pkg::denom_recip(cmd.idx)
                                 : vpc_pkg::RECIP_W'(vpc_pkg::denom_yen(cmd.idx));
   assign prod_in = vpc_pkg::PROD_W'(cmd.operand) * vpc_pkg::PROD_W'(factor);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

[rtl/vending_purchase_and_change_core.sv]
// Top level of the vending purchase and change core: sequencer, stores and result register.
//
// A request word is taken on req_word when req_valid is high and req_stall is low. The
// core then works on it alone and holds req_stall high until its result word has been
// taken on rsp_word (rsp_valid high, rsp_stall low); each request gives exactly one word.
// Slot product numbers and prices are written through csr_we, csr_index and csr_wdata;
// the user must write them only while the core is idle; the core does not enforce it.
// Add stock, a purchase of an unknown or sold-out product and an unknown coin value are
// answered from the lookup state, and the other coin requests from the coin state that
// follows it. A purchase builds the inserted total on the shared multiplier; one that falls
// short is answered after the price check, else change is paid one denomination at a time
// on the same multiplier (reciprocal estimate, back product, correction, clamp).
// After the result word is taken the core returns to idle and can take the next request.
// A stalled result word is held unchanged, and the core stays busy until it is taken.
// Reset returns the core to idle, with no result word offered, and restores the product
// numbers, prices, stock and coin counts to their initial contents.
`default_nettype none

`include "vending_purchase_and_change_core_assert.svh"

module vending_purchase_and_change_core #(
   parameter int NUM_SLOTS = vpc_pkg::NUM_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  vpc_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output vpc_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_we,
   input  logic [vpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vpc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int YEN_W      = vpc_pkg::YEN_W;
   localparam int STORE_W    = vpc_pkg::STORE_W;
   localparam int NDEN       = vpc_pkg::NUM_DENOMS;
   localparam logic [vpc_pkg::DENOM_IDX_W-1:0] LAST_DENOM =
      vpc_pkg::DENOM_IDX_W'(vpc_pkg::NUM_DENOMS - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIND, ST_COIN, ST_TOT, ST_TOT_END, ST_CHECK,
      ST_G_RECIP, ST_G_QUOT, ST_G_PICK, ST_G_STEP, ST_OUT
   } state_type;

   state_type                          state_ff, state_in;
   vpc_pkg::req_word_type              req_ff, req_in;
   logic [SLOT_IDX_W-1:0]              slot_ff, slot_in;
   logic [vpc_pkg::DENOM_IDX_W-1:0]    idx_ff, idx_in;
   logic [vpc_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic [YEN_W-1:0]                   total_ff, total_in;
   logic [YEN_W-1:0]                   change_ff, change_in;
   logic [YEN_W-1:0]                   rem_ff, rem_in;
   logic                               clamp_ff, clamp_in;
   logic [vpc_pkg::QUOT_W-1:0]         q0_ff, q0_in;
   logic [STORE_W-1:0]                 give_ff [NDEN];
   logic [STORE_W-1:0]                 give_in [NDEN];
   logic [STORE_W-1:0]                 coin_ff [NDEN];
   logic [STORE_W-1:0]                 coin_in [NDEN];
   logic [vpc_pkg::ID_W-1:0]           id_ff    [NUM_SLOTS];
   logic [vpc_pkg::ID_W-1:0]           id_in    [NUM_SLOTS];
   logic [vpc_pkg::PRICE_W-1:0]        price_ff [NUM_SLOTS];
   logic [vpc_pkg::PRICE_W-1:0]        price_in [NUM_SLOTS];
   logic [STORE_W-1:0]                 stock_ff [NUM_SLOTS];
   logic [STORE_W-1:0]                 stock_in [NUM_SLOTS];

   vpc_pkg::lookup_type                look;
   logic [SLOT_IDX_W-1:0]              look_slot;
   vpc_pkg::mul_cmd_type               mul_cmd;
   logic [vpc_pkg::PROD_W-1:0]         mul_prod;

   logic [STORE_W-1:0]                 store_sel;
   logic [vpc_pkg::PAID_W-1:0]         paid_sel;
   logic [vpc_pkg::DENOM_W-1:0]        yen_sel;
   logic [YEN_W-1:0]                   rem_raw;
   logic [YEN_W:0]                     rem_dif;
   logic                               rem_corr;
   logic [YEN_W-1:0]                   quot;
   logic                               clamp;
   logic [STORE_W-1:0]                 pick;

   vpc_lookup #(
      .NUM_SLOTS  (NUM_SLOTS),
      .SLOT_IDX_W (SLOT_IDX_W)
   ) u_lookup (
      .slot_id    (id_ff),
      .stock      (stock_ff),
      .product_id (req_ff.product_id),
      .need_stock (req_ff.req_type == vpc_pkg::REQ_PURCHASE),
      .coin_value (req_ff.coin_value),
      .look       (look),
      .slot_idx   (look_slot)
   );

   vpc_mul_unit u_mul (
      .clock (clock),
      .cmd   (mul_cmd),
      .prod  (mul_prod)
   );

   assign store_sel = coin_ff[idx_ff];
   assign paid_sel  = vpc_pkg::paid_count(req_ff, idx_ff);
   assign yen_sel   = vpc_pkg::denom_yen(idx_ff);
   assign rem_raw   = change_ff - mul_prod[YEN_W-1:0];
   assign rem_dif   = {1'b0, rem_raw} - (YEN_W + 1)'(yen_sel);
   assign rem_corr  = !rem_dif[YEN_W];
   assign quot      = YEN_W'(q0_ff) + YEN_W'(rem_corr);
   assign clamp     = quot > YEN_W'(store_sel);
   assign pick      = clamp ? store_sel : quot[STORE_W-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   assign rsp_word.status        = status_ff;
   assign rsp_word.total_paid    = total_ff;
   assign rsp_word.change_unpaid = change_ff;
   assign rsp_word.give_5000     = give_ff[0];
   assign rsp_word.give_1000     = give_ff[1];
   assign rsp_word.give_500      = give_ff[2];
   assign rsp_word.give_100      = give_ff[3];
   assign rsp_word.give_50       = give_ff[4];
   assign rsp_word.give_10       = give_ff[5];

   always_comb begin
      mul_cmd     = '0;
      mul_cmd.idx = idx_ff;
      unique case (state_ff)
         ST_TOT:     mul_cmd.operand = vpc_pkg::MUL_A_W'(paid_sel);
         ST_G_RECIP: begin
            mul_cmd.by_recip = 1'b1;
            mul_cmd.operand  = change_ff;
         end
         ST_G_QUOT:  mul_cmd.operand =
                        vpc_pkg::MUL_A_W'(mul_prod[vpc_pkg::PROD_W-1:vpc_pkg::RECIP_SHIFT]);
         ST_G_PICK:  mul_cmd.operand = vpc_pkg::MUL_A_W'(store_sel);
         default:    mul_cmd.operand = '0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      total_in  = total_ff;
      change_in = change_ff;
      rem_in    = rem_ff;
      clamp_in  = clamp_ff;
      q0_in     = q0_ff;
      give_in   = give_ff;
      coin_in   = coin_ff;
      id_in     = id_ff;
      price_in  = price_ff;
      stock_in  = stock_ff;

      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (s < vpc_pkg::CFG_SLOTS) begin
            if (csr_we && csr_index == vpc_pkg::CSR_SLOT0_ID + vpc_pkg::CSR_IDX_W'(s)) begin
               id_in[s] = csr_wdata[vpc_pkg::ID_W-1:0];
            end
            if (csr_we && csr_index == vpc_pkg::CSR_SLOT0_PRICE + vpc_pkg::CSR_IDX_W'(s)) begin
               price_in[s] = csr_wdata[vpc_pkg::PRICE_W-1:0];
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            status_in = vpc_pkg::STATUS_OK;
            total_in  = '0;
            change_in = '0;
            idx_in    = '0;
            for (int d = 0; d < NDEN; d++) begin
               give_in[d] = '0;
            end
            case (req_ff.req_type)
               vpc_pkg::REQ_PURCHASE: begin
                  if (look.slot_hit) begin
                     slot_in  = look_slot;
                     state_in = ST_TOT;
                  end else begin
                     status_in = vpc_pkg::STATUS_BAD_PRODUCT;
                     state_in  = ST_OUT;
                  end
               end
               vpc_pkg::REQ_ADD_STOCK: begin
                  if (look.slot_hit) begin
                     stock_in[look_slot] = vpc_pkg::sat_add(stock_ff[look_slot],
                                                            req_ff.quantity);
                  end else begin
                     status_in = vpc_pkg::STATUS_BAD_PRODUCT;
                  end
                  state_in = ST_OUT;
               end
               default: begin
                  if (look.denom_hit) begin
                     idx_in   = look.denom_idx;
                     state_in = ST_COIN;
                  end else begin
                     status_in = vpc_pkg::STATUS_BAD_COIN;
                     state_in  = ST_OUT;
                  end
               end
            endcase
         end
         ST_COIN: begin
            if (req_ff.req_type == vpc_pkg::REQ_ADD_COINS) begin
               coin_in[idx_ff] = vpc_pkg::sat_add(store_sel, req_ff.quantity);
            end else if (store_sel >= req_ff.quantity) begin
               coin_in[idx_ff] = store_sel - req_ff.quantity;
            end else begin
               status_in = vpc_pkg::STATUS_TOO_FEW;
            end
            state_in = ST_OUT;
         end
         ST_TOT: begin
            coin_in[idx_ff] = vpc_pkg::sat_add(store_sel, STORE_W'(paid_sel));
            if (idx_ff != '0) begin
               total_in = total_ff + mul_prod[YEN_W-1:0];
            end
            if (idx_ff == LAST_DENOM) begin
               state_in = ST_TOT_END;
            end else begin
               idx_in = idx_ff + vpc_pkg::DENOM_IDX_W'(1);
            end
         end
         ST_TOT_END: begin
            total_in = total_ff + mul_prod[YEN_W-1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (total_ff < YEN_W'(price_ff[slot_ff])) begin
               status_in = vpc_pkg::STATUS_SHORT_FUNDS;
               state_in  = ST_OUT;
            end else begin
               change_in         = total_ff - YEN_W'(price_ff[slot_ff]);
               stock_in[slot_ff] = stock_ff[slot_ff] - STORE_W'(1);
               idx_in            = '0;
               state_in          = ST_G_RECIP;
            end
         end
         ST_G_RECIP: begin
            state_in = ST_G_QUOT;
         end
         ST_G_QUOT: begin
            q0_in    = mul_prod[vpc_pkg::PROD_W-1:vpc_pkg::RECIP_SHIFT];
            state_in = ST_G_PICK;
         end
         ST_G_PICK: begin
            give_in[idx_ff] = pick;
            coin_in[idx_ff] = store_sel - pick;
            rem_in          = rem_corr ? rem_dif[YEN_W-1:0] : rem_raw;
            clamp_in        = clamp;
            state_in        = ST_G_STEP;
         end
         ST_G_STEP: begin
            change_in = clamp_ff ? change_ff - mul_prod[YEN_W-1:0] : rem_ff;
            if (idx_ff == LAST_DENOM) begin
               state_in = ST_OUT;
            end else begin
               idx_in   = idx_ff + vpc_pkg::DENOM_IDX_W'(1);
               state_in = ST_G_RECIP;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      slot_ff   <= slot_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      total_ff  <= total_in;
      change_ff <= change_in;
      rem_ff    <= rem_in;
      clamp_ff  <= clamp_in;
      q0_ff     <= q0_in;
      give_ff   <= give_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int d = 0; d < NDEN; d++) begin
            coin_ff[d] <= vpc_pkg::coin_reset(d);
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            id_ff[s]    <= vpc_pkg::slot_id_reset(s);
            price_ff[s] <= vpc_pkg::slot_price_reset(s);
            stock_ff[s] <= vpc_pkg::slot_stock_reset(s);
         end
      end else begin
         state_ff <= state_in;
         coin_ff  <= coin_in;
         id_ff    <= id_in;
         price_ff <= price_in;
         stock_ff <= stock_in;
      end
   end

   `VPC_ASSERT_SAME(a_busy_while_result, clock, reset, rsp_valid, req_stall,
                    "Request side open while a result word is pending.")
   `VPC_ASSERT_NEXT(a_no_instant_result, clock, reset, req_valid && !req_stall, !rsp_valid,
                    "Result word shown in the cycle after a request was taken.")
   `VPC_ASSERT_SAME(a_unpaid_bounded, clock, reset, rsp_valid,
                    rsp_word.change_unpaid <= rsp_word.total_paid,
                    "Unpaid change exceeds the inserted total.")

endmodule

`default_nettype wire

[sim/vending_purchase_and_change_core_tb.sv]
// Self-checking testbench for the vending purchase and change core: directed and random traffic.
module vending_purchase_and_change_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vpc_pkg::*;

   localparam int SLOTS        = NUM_SLOTS_DEF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS  = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int unsigned DENOM_VALUE [NUM_DENOMS] = '{5000, 1000, 500, 100, 50, 10};
   localparam int unsigned STORE_FULL = 65535;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [ID_W-1:0]    model_id    [SLOTS];
   logic [PRICE_W-1:0] model_price [SLOTS];
   logic [STORE_W-1:0] model_stock [SLOTS];
   logic [STORE_W-1:0] model_coins [NUM_DENOMS];
   logic [ID_W-1:0]    next_id     [SLOTS];
   logic [PRICE_W-1:0] next_price  [SLOTS];

   rsp_word_type expected_rsps [$];
   rsp_word_type oldest_rsp;
   bit           idle_enabled     = 1'b1;
   int unsigned  error_count      = 0;
   int unsigned  quiet_cycles     = 0;
   int unsigned  status_seen [5]  = '{default: 0};
   int unsigned  purchases_done   = 0;
   int unsigned  unpaid_purchases = 0;
   int unsigned  slot_settings    = 0;

   vending_purchase_and_change_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= idle_enabled && ($urandom_range(99) < 33);
   end

   function automatic logic [STORE_W-1:0] add_sat16(input logic [STORE_W-1:0] a,
                                                    input int unsigned b);
      int unsigned sum;
      sum = a + b;
      return (sum > STORE_FULL) ? STORE_W'(STORE_FULL) : STORE_W'(sum);
   endfunction

   function automatic int matching_slot(input logic [ID_W-1:0] id, input bit need_stock);
      int k;
      for (k = 0; k < SLOTS; k++) begin
         if (model_id[k] != '0 && model_id[k] == id && (!need_stock || model_stock[k] != '0))
            return k;
      end
      return -1;
   endfunction

   function automatic int denom_index(input logic [QTY_W-1:0] value);
      int d;
      for (d = 0; d < NUM_DENOMS; d++) begin
         if (DENOM_VALUE[d] == value)
            return d;
      end
      return -1;
   endfunction

   function automatic rsp_word_type predict_rsp(input req_word_type w);
      rsp_word_type       r;
      logic [PAID_W-1:0]  paid [NUM_DENOMS];
      logic [STORE_W-1:0] give [NUM_DENOMS];
      int                 slot;
      int                 denom;
      int                 d;
      int unsigned        total;
      int unsigned        change;
      int unsigned        count;
      r      = '0;
      total  = 0;
      change = 0;
      paid   = '{w.paid_5000, w.paid_1000, w.paid_500, w.paid_100, w.paid_50, w.paid_10};
      give   = '{default: '0};
      case (w.req_type)
         REQ_PURCHASE: begin
            slot = matching_slot(w.product_id, 1'b1);
            if (slot < 0) begin
               r.status = STATUS_BAD_PRODUCT;
            end else begin
               for (d = 0; d < NUM_DENOMS; d++) begin
                  total += DENOM_VALUE[d] * paid[d];
                  model_coins[d] = add_sat16(model_coins[d], paid[d]);
               end
               if (total < model_price[slot]) begin
                  r.status = STATUS_SHORT_FUNDS;
               end else begin
                  change = total - model_price[slot];
                  model_stock[slot] = model_stock[slot] - 16'd1;
                  for (d = 0; d < NUM_DENOMS; d++) begin
                     count = change / DENOM_VALUE[d];
                     if (count > model_coins[d])
                        count = model_coins[d];
                     give[d] = STORE_W'(count);
                     change -= count * DENOM_VALUE[d];
                     model_coins[d] = model_coins[d] - STORE_W'(count);
                  end
                  purchases_done++;
                  if (change != 0)
                     unpaid_purchases++;
               end
            end
         end
         REQ_ADD_STOCK: begin
            slot = matching_slot(w.product_id, 1'b0);
            if (slot < 0)
               r.status = STATUS_BAD_PRODUCT;
            else
               model_stock[slot] = add_sat16(model_stock[slot], w.quantity);
         end
         default: begin
            denom = denom_index(w.coin_value);
            if (denom < 0)
               r.status = STATUS_BAD_COIN;
            else if (w.req_type == REQ_ADD_COINS)
               model_coins[denom] = add_sat16(model_coins[denom], w.quantity);
            else if (model_coins[denom] >= w.quantity)
               model_coins[denom] = model_coins[denom] - w.quantity;
            else
               r.status = STATUS_TOO_FEW;
         end
      endcase
      r.total_paid    = YEN_W'(total);
      r.change_unpaid = YEN_W'(change);
      r.give_5000     = give[0];
      r.give_1000     = give[1];
      r.give_500      = give[2];
      r.give_100      = give[3];
      r.give_50       = give[4];
      r.give_10       = give[5];
      status_seen[r.status]++;
      return r;
   endfunction

   task automatic reset_model();
      model_id    = '{8'd1, 8'd2, 8'd3};
      model_price = '{16'd150, 16'd100, 16'd200};
      model_stock = '{16'd10, 16'd15, 16'd8};
      model_coins = '{16'd10, 16'd20, 16'd30, 16'd50, 16'd100, 16'd200};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result word with no request outstanding: %h", rsp_word);
            error_count++;
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            check_field("status", oldest_rsp.status, rsp_word.status);
            check_field("total_paid", oldest_rsp.total_paid, rsp_word.total_paid);
            check_field("change_unpaid", oldest_rsp.change_unpaid, rsp_word.change_unpaid);
            check_field("give_5000", oldest_rsp.give_5000, rsp_word.give_5000);
            check_field("give_1000", oldest_rsp.give_1000, rsp_word.give_1000);
            check_field("give_500", oldest_rsp.give_500, rsp_word.give_500);
            check_field("give_100", oldest_rsp.give_100, rsp_word.give_100);
            check_field("give_50", oldest_rsp.give_50, rsp_word.give_50);
            check_field("give_10", oldest_rsp.give_10, rsp_word.give_10);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Called at a falling edge; returns at a falling edge with the word still offered.
   task automatic send_req(input req_word_type w);
      while (idle_enabled && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      expected_rsps.push_back(predict_rsp(w));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_slots(input bit poke_spare);
      int k;
      wait_idle();
      for (k = 0; k < SLOTS; k++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_SLOT0_ID + CSR_IDX_W'(k);
         csr_wdata <= {8'($urandom), next_id[k]};
         @(negedge clock);
         model_id[k] = next_id[k];
         csr_index <= CSR_SLOT0_PRICE + CSR_IDX_W'(k);
         csr_wdata <= next_price[k];
         @(negedge clock);
         model_price[k] = next_price[k];
      end
      if (poke_spare) begin
         csr_index <= CSR_SPARE_LO;
         csr_wdata <= 16'($urandom);
         @(negedge clock);
         csr_index <= CSR_SPARE_HI;
         csr_wdata <= 16'($urandom);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      slot_settings++;
      @(negedge clock);
   endtask

   function automatic req_word_type make_purchase(input int unsigned pid, input int unsigned n5000,
                                                  input int unsigned n1000, input int unsigned n500,
                                                  input int unsigned n100, input int unsigned n50,
                                                  input int unsigned n10);
      req_word_type w;
      w            = '0;
      w.req_type   = REQ_PURCHASE;
      w.product_id = ID_W'(pid);
      w.paid_5000  = PAID_W'(n5000);
      w.paid_1000  = PAID_W'(n1000);
      w.paid_500   = PAID_W'(n500);
      w.paid_100   = PAID_W'(n100);
      w.paid_50    = PAID_W'(n50);
      w.paid_10    = PAID_W'(n10);
      return w;
   endfunction

   function automatic req_word_type make_request(input logic [REQ_W-1:0] kind,
                                                 input int unsigned pid, input int unsigned qty,
                                                 input int unsigned value);
      req_word_type w;
      w            = '0;
      w.req_type   = kind;
      w.product_id = ID_W'(pid);
      w.quantity   = QTY_W'(qty);
      w.coin_value = QTY_W'(value);
      return w;
   endfunction

   function automatic logic [PAID_W-1:0] random_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6)
         return PAID_W'($urandom_range(255));
      else if (r < 55)
         return '0;
      else
         return PAID_W'($urandom_range(3, 1));
   endfunction

   function automatic logic [QTY_W-1:0] random_amount();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5)
         return QTY_W'(STORE_FULL);
      else if (r < 10)
         return QTY_W'($urandom_range(65535));
      else
         return QTY_W'($urandom_range(20));
   endfunction

   function automatic logic [QTY_W-1:0] random_denom();
      if ($urandom_range(99) < 85)
         return QTY_W'(DENOM_VALUE[$urandom_range(NUM_DENOMS - 1)]);
      else
         return QTY_W'($urandom_range(65535));
   endfunction

   function automatic logic [ID_W-1:0] random_pid();
      if ($urandom_range(99) < 85)
         return model_id[$urandom_range(SLOTS - 1)];
      else
         return ID_W'($urandom_range(255));
   endfunction

   function automatic req_word_type random_req();
      req_word_type w;
      int unsigned  pick;
      w.req_type   = REQ_W'($urandom_range(3));
      w.product_id = ID_W'($urandom);
      w.quantity   = QTY_W'($urandom);
      w.coin_value = QTY_W'($urandom);
      w.paid_5000  = PAID_W'($urandom);
      w.paid_1000  = PAID_W'($urandom);
      w.paid_500   = PAID_W'($urandom);
      w.paid_100   = PAID_W'($urandom);
      w.paid_50    = PAID_W'($urandom);
      w.paid_10    = PAID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
         w.req_type   = REQ_PURCHASE;
         w.product_id = random_pid();
         w.paid_5000  = random_count();
         w.paid_1000  = random_count();
         w.paid_500   = random_count();
         w.paid_100   = random_count();
         w.paid_50    = random_count();
         w.paid_10    = random_count();
      end else if (pick < 70) begin
         w.req_type   = REQ_ADD_STOCK;
         w.product_id = random_pid();
         w.quantity   = random_amount();
      end else if (pick < 85) begin
         w.req_type   = REQ_ADD_COINS;
         w.coin_value = random_denom();
         w.quantity   = random_amount();
      end else if (pick < 98) begin
         w.req_type   = REQ_REDUCE_COINS;
         w.coin_value = random_denom();
         w.quantity   = random_amount();
      end
      return w;
   endfunction

   function automatic logic [ID_W-1:0] random_slot_id();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)
         return '0;
      else if (r < 20)
         return ID_W'(255);
      else
         return ID_W'($urandom_range(6, 1));
   endfunction

   function automatic logic [PRICE_W-1:0] random_price();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)
         return '0;
      else if (r < 20)
         return PRICE_W'(STORE_FULL);
      else if (r < 60)
         return PRICE_W'(10 * $urandom_range(300, 1));
      else
         return PRICE_W'($urandom_range(65535));
   endfunction

   task automatic test_default_slots();
      send_req(make_purchase(1, 0, 0, 0, 1, 1, 0));
      send_req(make_purchase(2, 0, 1, 0, 0, 0, 0));
      send_req(make_purchase(3, 255, 255, 255, 255, 255, 255));
      send_req(make_purchase(2, 0, 0, 0, 0, 0, 0));
      send_req(make_purchase(0, 0, 0, 0, 2, 0, 0));
      send_req(make_purchase(255, 1, 0, 0, 0, 0, 0));
      send_req(make_request(REQ_ADD_STOCK, 9, 5, 0));
      send_req(make_request(REQ_ADD_STOCK, 1, 65535, 0));
      send_req(make_request(REQ_ADD_STOCK, 0, 1, 0));
      send_req(make_request(REQ_ADD_COINS, 0, 1, 0));
      send_req(make_request(REQ_ADD_COINS, 0, 1, 65535));
      send_req(make_request(REQ_REDUCE_COINS, 0, 1, 7));
      send_req(make_request(REQ_ADD_COINS, 0, 65535, 10));
      send_req(make_request(REQ_REDUCE_COINS, 0, 65535, 5000));
      send_req(make_request(REQ_REDUCE_COINS, 0, 65535, 10));
      // The third product runs out part way through this loop.
      repeat (8) send_req(make_purchase(3, 0, 0, 1, 0, 0, 0));
   endtask

   task automatic test_slot_registers();
      next_id    = '{8'd5, 8'd5, 8'd0};
      next_price = '{16'd0, 16'hFFFF, 16'hFFFF};
      load_slots(1'b1);
      send_req(make_purchase(5, 0, 0, 0, 0, 0, 1));
      send_req(make_purchase(0, 0, 0, 0, 0, 0, 1));
      send_req(make_request(REQ_ADD_STOCK, 5, 3, 0));
      next_id    = '{8'd7, 8'd7, 8'd255};
      next_price = '{16'hFFFF, 16'd150, 16'd12345};
      load_slots(1'b0);
      send_req(make_purchase(255, 14, 0, 0, 0, 0, 0));
      send_req(make_purchase(7, 13, 0, 0, 0, 0, 0));
      send_req(make_purchase(7, 14, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      int k;
      for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
         if (phase == 1) begin
            next_id    = '{8'd255, 8'd255, 8'd0};
            next_price = '{16'hFFFF, 16'd0, 16'hFFFF};
         end else if (phase == 6) begin
            next_id    = '{8'd4, 8'd4, 8'd4};
            next_price = '{16'd0, 16'd10, 16'hFFFF};
         end else begin
            for (k = 0; k < SLOTS; k++) begin
               next_id[k]    = random_slot_id();
               next_price[k] = random_price();
            end
         end
         load_slots(phase % 2 == 1);
         idle_enabled = (phase != 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2)
               wait_idle();
            send_req(random_req());
         end
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_slots();
      test_slot_registers();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Requests checked by status: ok %0d, bad product %0d, short funds %0d, bad coin %0d, too few coins %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      $display("Purchases completed %0d (%0d with change left unpaid) over %0d slot settings",
               purchases_done, unpaid_purchases, slot_settings);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
